@@ hw/rtl/lfdra_pkg.sv @@
// Shared types and constants for the light-field disparity remap address block.
// Used by lfdra_cfg and light_field_disparity_remap_address.
package lfdra_pkg;

    localparam int MAX_SPATIAL = 4096;
    localparam int MAX_VIEWS   = 256;

    // field widths
    localparam int X_W     = 12;              // pixel coordinate
    localparam int V_W     = 8;               // view index
    localparam int EXT_W   = 13;              // spatial extent register
    localparam int VEXT_W  = 9;               // view count register
    localparam int STEP_W  = 32;              // disparity step
    localparam int IDX_W   = 40;              // linear index
    localparam int SUM_W   = EXT_W + 1;       // wrap adder

    // datapath widths
    localparam int VYVA_W  = V_W + VEXT_W;    // view row times views across
    localparam int BASE_W  = 16;              // view number
    localparam int BH_MUL_W = BASE_W + EXT_W;
    localparam int BH_W    = 28;              // view number times height, plus y
    localparam int IDX_MUL_W = BH_W + EXT_W;
    localparam int SHIFT_W = V_W + STEP_W;    // shift magnitude

    // APB
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_SPATIAL_WIDTH   = 3'd0,
        REG_SPATIAL_HEIGHT  = 3'd1,
        REG_VIEWS_ACROSS    = 3'd2,
        REG_VIEWS_DOWN      = 3'd3,
        REG_HORIZONTAL_STEP = 3'd4,
        REG_VERTICAL_STEP   = 3'd5,
        REG_INVERSE_MODE    = 3'd6
    } t_reg_idx;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [EXT_W-1:0]  w;
        logic [EXT_W-1:0]  h;
        logic [VEXT_W-1:0] va;
        logic [VEXT_W-1:0] vd;
        logic [V_W-1:0]    half_va;
        logic [V_W-1:0]    half_vd;
        logic [STEP_W-1:0] hmag;
        logic              hneg;
        logic [STEP_W-1:0] vmag;
        logic              vneg;
        logic              inv;
    } t_cfg;

    // per-item fields carried alongside the shift remainder
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] y;
        logic           hneg;
        logic           vneg;
    } t_mid;

endpackage

@@ hw/rtl/lfdra_rem_pipe.sv @@
// Pipelined restoring remainder: numerator modulo a static divisor, STEPS bits per stage.
// Depends on nothing; stage enables come from the parent's pipeline control.
module lfdra_rem_pipe #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 13,
    parameter int STEPS = 6,
    localparam int NSTG = (NUM_W + STEPS - 1) / STEPS
) (
    input  logic             i_clk,
    input  logic [NSTG-1:0]  i_take,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [DEN_W-1:0] o_rem
);

    localparam int PAD_W = NSTG * STEPS;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        localparam int IN_W = PAD_W - s * STEPS;

        logic [DEN_W-1:0] rem_in;
        logic [IN_W-1:0]  num_in;
        logic [DEN_W-1:0] n_rem;
        logic [DEN_W-1:0] r_rem;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = IN_W'(i_num);
        end else begin : g_next
            assign rem_in = g_stg[s-1].r_rem;
            assign num_in = g_stg[s-1].g_num.r_num;
        end

        always_comb begin
            logic [DEN_W:0] trial;
            n_rem = rem_in;
            for (int k = 0; k < STEPS; k++) begin
                trial = {n_rem, num_in[IN_W-1-k]};
                if (trial >= {1'b0, i_den}) begin
                    trial = trial - {1'b0, i_den};
                end
                n_rem = trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_take[s]) begin
                r_rem <= n_rem;
            end
        end

        // numerator bits still to be consumed by later stages
        if (s < NSTG - 1) begin : g_num
            logic [IN_W-STEPS-1:0] r_num;
            always_ff @(posedge i_clk) begin
                if (i_take[s]) begin
                    r_num <= num_in[IN_W-STEPS-1:0];
                end
            end
        end
    end

    assign o_rem = g_stg[NSTG-1].r_rem;

endmodule

@@ hw/rtl/lfdra_cfg.sv @@
// APB register file: raw registers for readback plus clamped extents and step magnitudes.
// Depends on lfdra_pkg.
module lfdra_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfdra_pkg::ADDR_W-1:0]  paddr,
    input  logic [lfdra_pkg::DATA_W-1:0]  pwdata,
    output logic [lfdra_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output lfdra_pkg::t_cfg               o_cfg
);

    logic [lfdra_pkg::EXT_W-1:0]  r_spatial_width;
    logic [lfdra_pkg::EXT_W-1:0]  r_spatial_height;
    logic [lfdra_pkg::VEXT_W-1:0] r_views_across;
    logic [lfdra_pkg::VEXT_W-1:0] r_views_down;
    logic [lfdra_pkg::STEP_W-1:0] r_horizontal_step;
    logic [lfdra_pkg::STEP_W-1:0] r_vertical_step;
    logic                         r_inverse_mode;

    logic [lfdra_pkg::EXT_W-1:0]  r_w;
    logic [lfdra_pkg::EXT_W-1:0]  r_h;
    logic [lfdra_pkg::VEXT_W-1:0] r_va;
    logic [lfdra_pkg::VEXT_W-1:0] r_vd;
    logic [lfdra_pkg::STEP_W-1:0] r_hmag;
    logic                         r_hneg;
    logic [lfdra_pkg::STEP_W-1:0] r_vmag;
    logic                         r_vneg;

    lfdra_pkg::t_reg_idx          idx;
    logic                         wr;
    logic [lfdra_pkg::STEP_W-1:0] step_mag;

    function automatic logic [lfdra_pkg::EXT_W-1:0] clamp_spatial(
        input logic [lfdra_pkg::EXT_W-1:0] v
    );
        logic [lfdra_pkg::EXT_W-1:0] res;
        if (v == '0) begin
            res = lfdra_pkg::EXT_W'(1);
        end else if (v > lfdra_pkg::EXT_W'(lfdra_pkg::MAX_SPATIAL)) begin
            res = lfdra_pkg::EXT_W'(lfdra_pkg::MAX_SPATIAL);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [lfdra_pkg::VEXT_W-1:0] clamp_views(
        input logic [lfdra_pkg::VEXT_W-1:0] v
    );
        logic [lfdra_pkg::VEXT_W-1:0] res;
        if (v == '0) begin
            res = lfdra_pkg::VEXT_W'(1);
        end else if (v > lfdra_pkg::VEXT_W'(lfdra_pkg::MAX_VIEWS)) begin
            res = lfdra_pkg::VEXT_W'(lfdra_pkg::MAX_VIEWS);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign idx      = lfdra_pkg::t_reg_idx'(paddr[lfdra_pkg::ADDR_W-1:2]);
    assign wr       = psel && penable && pwrite;
    assign step_mag = pwdata[lfdra_pkg::STEP_W-1] ? (~pwdata + 1'b1) : pwdata;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spatial_width   <= lfdra_pkg::EXT_W'(1);
            r_spatial_height  <= lfdra_pkg::EXT_W'(1);
            r_views_across    <= lfdra_pkg::VEXT_W'(1);
            r_views_down      <= lfdra_pkg::VEXT_W'(1);
            r_horizontal_step <= '0;
            r_vertical_step   <= '0;
            r_inverse_mode    <= 1'b0;
            r_w               <= lfdra_pkg::EXT_W'(1);
            r_h               <= lfdra_pkg::EXT_W'(1);
            r_va              <= lfdra_pkg::VEXT_W'(1);
            r_vd              <= lfdra_pkg::VEXT_W'(1);
            r_hmag            <= '0;
            r_hneg            <= 1'b0;
            r_vmag            <= '0;
            r_vneg            <= 1'b0;
        end else if (wr) begin
            case (idx)
                lfdra_pkg::REG_SPATIAL_WIDTH: begin
                    r_spatial_width <= pwdata[lfdra_pkg::EXT_W-1:0];
                    r_w             <= clamp_spatial(pwdata[lfdra_pkg::EXT_W-1:0]);
                end
                lfdra_pkg::REG_SPATIAL_HEIGHT: begin
                    r_spatial_height <= pwdata[lfdra_pkg::EXT_W-1:0];
                    r_h              <= clamp_spatial(pwdata[lfdra_pkg::EXT_W-1:0]);
                end
                lfdra_pkg::REG_VIEWS_ACROSS: begin
                    r_views_across <= pwdata[lfdra_pkg::VEXT_W-1:0];
                    r_va           <= clamp_views(pwdata[lfdra_pkg::VEXT_W-1:0]);
                end
                lfdra_pkg::REG_VIEWS_DOWN: begin
                    r_views_down <= pwdata[lfdra_pkg::VEXT_W-1:0];
                    r_vd         <= clamp_views(pwdata[lfdra_pkg::VEXT_W-1:0]);
                end
                lfdra_pkg::REG_HORIZONTAL_STEP: begin
                    r_horizontal_step <= pwdata;
                    r_hmag            <= step_mag;
                    r_hneg            <= pwdata[lfdra_pkg::STEP_W-1];
                end
                lfdra_pkg::REG_VERTICAL_STEP: begin
                    r_vertical_step <= pwdata;
                    r_vmag          <= step_mag;
                    r_vneg          <= pwdata[lfdra_pkg::STEP_W-1];
                end
                lfdra_pkg::REG_INVERSE_MODE: begin
                    r_inverse_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            lfdra_pkg::REG_SPATIAL_WIDTH:   prdata = lfdra_pkg::DATA_W'(r_spatial_width);
            lfdra_pkg::REG_SPATIAL_HEIGHT:  prdata = lfdra_pkg::DATA_W'(r_spatial_height);
            lfdra_pkg::REG_VIEWS_ACROSS:    prdata = lfdra_pkg::DATA_W'(r_views_across);
            lfdra_pkg::REG_VIEWS_DOWN:      prdata = lfdra_pkg::DATA_W'(r_views_down);
            lfdra_pkg::REG_HORIZONTAL_STEP: prdata = r_horizontal_step;
            lfdra_pkg::REG_VERTICAL_STEP:   prdata = r_vertical_step;
            lfdra_pkg::REG_INVERSE_MODE:    prdata = lfdra_pkg::DATA_W'(r_inverse_mode);
            default:                        prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.w       = r_w;
        o_cfg.h       = r_h;
        o_cfg.va      = r_va;
        o_cfg.vd      = r_vd;
        o_cfg.half_va = r_va[lfdra_pkg::VEXT_W-1:1];
        o_cfg.half_vd = r_vd[lfdra_pkg::VEXT_W-1:1];
        o_cfg.hmag    = r_hmag;
        o_cfg.hneg    = r_hneg;
        o_cfg.vmag    = r_vmag;
        o_cfg.vneg    = r_vneg;
        o_cfg.inv     = r_inverse_mode;
    end

endmodule

@@ hw/rtl/light_field_disparity_remap_address.sv @@
// Light-field disparity remap address generator. Each item is a pixel coordinate
// (x, y, view column, view row); each result is the pair of 40-bit linear indices
// (read, write; swapped in inverse mode) with x fastest, the source pixel shifted circularly by the view's
// offset from the centre view times the per-axis disparity step. The block takes one
// item per clock unless i_out_ready stalls the output; the work runs in a 12-stage
// pipeline: two stages reduce the coordinates, one forms the shift products, five
// reduce the 40-bit shift modulo the extent eight bits per stage, and four wrap the
// coordinates and build the source index. Registers sit on the APB port at
// byte address 4*i: spatial_width, spatial_height, views_across, views_down,
// horizontal_step, vertical_step, inverse_mode. Write them only while no item is in
// flight. Depends on lfdra_pkg, lfdra_cfg and lfdra_rem_pipe.
module light_field_disparity_remap_address (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfdra_pkg::ADDR_W-1:0]  paddr,
    input  logic [lfdra_pkg::DATA_W-1:0]  pwdata,
    output logic [lfdra_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lfdra_pkg::X_W-1:0]     i_pixel_x,
    input  logic [lfdra_pkg::X_W-1:0]     i_pixel_y,
    input  logic [lfdra_pkg::V_W-1:0]     i_view_col,
    input  logic [lfdra_pkg::V_W-1:0]     i_view_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfdra_pkg::IDX_W-1:0]   o_read_index,
    output logic [lfdra_pkg::IDX_W-1:0]   o_write_index
);

    localparam int N_STG = 12;

    lfdra_pkg::t_cfg cfg;

    logic [N_STG:1] take;
    logic [N_STG:1] r_v;
    logic [N_STG:1] v_prev;

    logic [lfdra_pkg::EXT_W-1:0]  rem_x;
    logic [lfdra_pkg::EXT_W-1:0]  rem_y;
    logic [lfdra_pkg::VEXT_W-1:0] rem_vx;
    logic [lfdra_pkg::VEXT_W-1:0] rem_vy;
    logic [lfdra_pkg::EXT_W-1:0]  rem_h;
    logic [lfdra_pkg::EXT_W-1:0]  rem_v;

    // stage 2
    logic [lfdra_pkg::V_W-1:0]    vx1;
    logic [lfdra_pkg::V_W-1:0]    vy1;
    logic [lfdra_pkg::V_W-1:0]    dxmag;
    logic [lfdra_pkg::V_W-1:0]    dymag;
    logic                         dxneg;
    logic                         dyneg;
    logic [lfdra_pkg::VYVA_W-1:0] vyva_full;
    logic [lfdra_pkg::V_W-1:0]    r2_dxmag;
    logic [lfdra_pkg::V_W-1:0]    r2_dymag;
    logic                         r2_dxneg;
    logic                         r2_dyneg;
    logic [lfdra_pkg::BASE_W-1:0] r2_vyva;
    logic [lfdra_pkg::V_W-1:0]    r2_vx;

    // stage 3
    logic [lfdra_pkg::SHIFT_W-1:0] hprod;
    logic [lfdra_pkg::SHIFT_W-1:0] vprod;
    logic [lfdra_pkg::SHIFT_W-1:0] r3_hprod;
    logic [lfdra_pkg::SHIFT_W-1:0] r3_vprod;
    logic [lfdra_pkg::BASE_W-1:0]  r3_base;

    // later stages
    lfdra_pkg::t_mid                r_mid [3:8];
    logic [lfdra_pkg::BH_MUL_W-1:0] bh_full;
    logic [lfdra_pkg::BH_W-1:0]     r_bh  [4:9];
    logic [lfdra_pkg::BH_W-1:0]     r5_dsum;
    logic [lfdra_pkg::IDX_MUL_W-1:0] dprod_full;
    logic [lfdra_pkg::IDX_W-1:0]    r6_dprod;
    logic [lfdra_pkg::IDX_W-1:0]    r_dst [7:11];
    logic [lfdra_pkg::X_W-1:0]      r9_sx;
    logic [lfdra_pkg::X_W-1:0]      r9_sy;
    logic [lfdra_pkg::BH_W-1:0]     r10_ssum;
    logic [lfdra_pkg::X_W-1:0]      r10_sx;
    logic [lfdra_pkg::IDX_MUL_W-1:0] sprod_full;
    logic [lfdra_pkg::IDX_W-1:0]    r11_sprod;
    logic [lfdra_pkg::X_W-1:0]      r11_sx;
    logic [lfdra_pkg::IDX_W-1:0]    src;
    logic [lfdra_pkg::IDX_W-1:0]    r_read_index;
    logic [lfdra_pkg::IDX_W-1:0]    r_write_index;

    // (c + shift) mod ext, given r = |shift| mod ext and c, r below ext
    function automatic logic [lfdra_pkg::X_W-1:0] wrap_coord(
        input logic [lfdra_pkg::X_W-1:0]   c,
        input logic [lfdra_pkg::X_W-1:0]   r,
        input logic [lfdra_pkg::EXT_W-1:0] ext,
        input logic                        neg
    );
        logic [lfdra_pkg::SUM_W-1:0] sum;
        sum = '0;
        if (neg) begin
            if (c >= r) begin
                sum = lfdra_pkg::SUM_W'(c) - lfdra_pkg::SUM_W'(r);
            end else begin
                sum = lfdra_pkg::SUM_W'(c) + lfdra_pkg::SUM_W'(ext) - lfdra_pkg::SUM_W'(r);
            end
        end else begin
            sum = lfdra_pkg::SUM_W'(c) + lfdra_pkg::SUM_W'(r);
            if (sum >= lfdra_pkg::SUM_W'(ext)) begin
                sum = sum - lfdra_pkg::SUM_W'(ext);
            end
        end
        return sum[lfdra_pkg::X_W-1:0];
    endfunction

    lfdra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pipeline control
    always_comb begin
        take[N_STG] = !r_v[N_STG] || i_out_ready;
        for (int k = N_STG - 1; k >= 1; k--) begin
            take[k] = !r_v[k] || take[k+1];
        end
    end

    assign v_prev      = {r_v[N_STG-1:1], i_in_valid};
    assign o_in_ready  = take[1];
    assign o_out_valid = r_v[N_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= N_STG; k++) begin
                if (take[k]) begin
                    r_v[k] <= v_prev[k];
                end
            end
        end
    end

    // stages 1-2: coordinates reduced modulo their extents
    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::X_W), .DEN_W(lfdra_pkg::EXT_W), .STEPS(6)) u_rem_x (
        .i_clk (i_clk), .i_take (take[2:1]), .i_num (i_pixel_x), .i_den (cfg.w),
        .o_rem (rem_x)
    );

    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::X_W), .DEN_W(lfdra_pkg::EXT_W), .STEPS(6)) u_rem_y (
        .i_clk (i_clk), .i_take (take[2:1]), .i_num (i_pixel_y), .i_den (cfg.h),
        .o_rem (rem_y)
    );

    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::V_W), .DEN_W(lfdra_pkg::VEXT_W), .STEPS(8)) u_rem_vx (
        .i_clk (i_clk), .i_take (take[1:1]), .i_num (i_view_col), .i_den (cfg.va),
        .o_rem (rem_vx)
    );

    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::V_W), .DEN_W(lfdra_pkg::VEXT_W), .STEPS(8)) u_rem_vy (
        .i_clk (i_clk), .i_take (take[1:1]), .i_num (i_view_row), .i_den (cfg.vd),
        .o_rem (rem_vy)
    );

    // stage 2: view offsets from centre, row product
    assign vx1 = rem_vx[lfdra_pkg::V_W-1:0];
    assign vy1 = rem_vy[lfdra_pkg::V_W-1:0];

    always_comb begin
        if (vx1 >= cfg.half_va) begin
            dxmag = vx1 - cfg.half_va;
            dxneg = 1'b0;
        end else begin
            dxmag = cfg.half_va - vx1;
            dxneg = 1'b1;
        end
        if (vy1 >= cfg.half_vd) begin
            dymag = vy1 - cfg.half_vd;
            dyneg = 1'b0;
        end else begin
            dymag = cfg.half_vd - vy1;
            dyneg = 1'b1;
        end
    end

    assign vyva_full = lfdra_pkg::VYVA_W'(vy1) * lfdra_pkg::VYVA_W'(cfg.va);

    always_ff @(posedge i_clk) begin
        if (take[2]) begin
            r2_dxmag <= dxmag;
            r2_dxneg <= dxneg;
            r2_dymag <= dymag;
            r2_dyneg <= dyneg;
            r2_vyva  <= vyva_full[lfdra_pkg::BASE_W-1:0];
            r2_vx    <= vx1;
        end
    end

    // stage 3: shift magnitudes, view number
    assign hprod = lfdra_pkg::SHIFT_W'(r2_dxmag) * lfdra_pkg::SHIFT_W'(cfg.hmag);
    assign vprod = lfdra_pkg::SHIFT_W'(r2_dymag) * lfdra_pkg::SHIFT_W'(cfg.vmag);

    always_ff @(posedge i_clk) begin
        if (take[3]) begin
            r3_hprod      <= hprod;
            r3_vprod      <= vprod;
            r3_base       <= r2_vyva + lfdra_pkg::BASE_W'(r2_vx);
        end
    end

    // stages 4-8: shift magnitudes modulo the extents
    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::SHIFT_W), .DEN_W(lfdra_pkg::EXT_W), .STEPS(8)) u_rem_h (
        .i_clk (i_clk), .i_take (take[8:4]), .i_num (r3_hprod), .i_den (cfg.w),
        .o_rem (rem_h)
    );

    lfdra_rem_pipe #(.NUM_W(lfdra_pkg::SHIFT_W), .DEN_W(lfdra_pkg::EXT_W), .STEPS(8)) u_rem_v (
        .i_clk (i_clk), .i_take (take[8:4]), .i_num (r3_vprod), .i_den (cfg.h),
        .o_rem (rem_v)
    );

    // destination index alongside the remainder stages
    assign bh_full    = lfdra_pkg::BH_MUL_W'(r3_base) * lfdra_pkg::BH_MUL_W'(cfg.h);
    assign dprod_full = lfdra_pkg::IDX_MUL_W'(r5_dsum) * lfdra_pkg::IDX_MUL_W'(cfg.w);
    assign sprod_full = lfdra_pkg::IDX_MUL_W'(r10_ssum) * lfdra_pkg::IDX_MUL_W'(cfg.w);
    assign src        = r11_sprod + lfdra_pkg::IDX_W'(r11_sx);

    always_ff @(posedge i_clk) begin
        if (take[3]) begin
            r_mid[3].x    <= rem_x[lfdra_pkg::X_W-1:0];
            r_mid[3].y    <= rem_y[lfdra_pkg::X_W-1:0];
            r_mid[3].hneg <= r2_dxneg ^ cfg.hneg;
            r_mid[3].vneg <= r2_dyneg ^ cfg.vneg;
        end
        for (int k = 4; k <= 8; k++) begin
            if (take[k]) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
        for (int k = 5; k <= 9; k++) begin
            if (take[k]) begin
                r_bh[k] <= r_bh[k-1];
            end
        end
        for (int k = 8; k <= 11; k++) begin
            if (take[k]) begin
                r_dst[k] <= r_dst[k-1];
            end
        end
        if (take[4]) begin
            r_bh[4] <= bh_full[lfdra_pkg::BH_W-1:0];
        end
        if (take[5]) begin
            r5_dsum <= r_bh[4] + lfdra_pkg::BH_W'(r_mid[4].y);
        end
        if (take[6]) begin
            r6_dprod <= dprod_full[lfdra_pkg::IDX_W-1:0];
        end
        if (take[7]) begin
            r_dst[7] <= r6_dprod + lfdra_pkg::IDX_W'(r_mid[6].x);
        end
        // stage 9: shifted source coordinate
        if (take[9]) begin
            r9_sx <= wrap_coord(r_mid[8].x, rem_h[lfdra_pkg::X_W-1:0], cfg.w, r_mid[8].hneg);
            r9_sy <= wrap_coord(r_mid[8].y, rem_v[lfdra_pkg::X_W-1:0], cfg.h, r_mid[8].vneg);
        end
        if (take[10]) begin
            r10_ssum <= r_bh[9] + lfdra_pkg::BH_W'(r9_sy);
            r10_sx   <= r9_sx;
        end
        if (take[11]) begin
            r11_sprod <= sprod_full[lfdra_pkg::IDX_W-1:0];
            r11_sx    <= r10_sx;
        end
        if (take[12]) begin
            r_read_index  <= cfg.inv ? r_dst[11] : src;
            r_write_index <= cfg.inv ? src : r_dst[11];
        end
    end

    assign o_read_index  = r_read_index;
    assign o_write_index = r_write_index;

endmodule
